// File: hdl/buzzer_pattern_sequencer_top_macros.svh
// Assertion macros shared by the buzzer sequencer checker.
`ifndef BUZZER_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bps_pkg.sv
// Types and constants for the buzzer pattern sequencer.
`default_nettype none

package bps_pkg;

  localparam int FREQ_W  = 16;
  localparam int TICKS_W = 16;
  localparam int COUNT_W = 8;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 3;
  // Elapsed counter: one bit past the tick registers is enough to saturate
  // above every reachable compare value.
  localparam int EL_W    = TICKS_W + 1;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_ALARM   = 3'd1;
  localparam logic [OP_W-1:0] OP_BEEP    = 3'd2;
  localparam logic [OP_W-1:0] OP_CONFIRM = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
  localparam logic [OP_W-1:0] OP_MUTE    = 3'd5;
  localparam logic [OP_W-1:0] OP_UNMUTE  = 3'd6;

  localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ALARM_ON  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ALARM_OFF = 3'd2;
  localparam logic [IDX_W-1:0] REG_BEEP_ON   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BEEP_OFF  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CRIT_FREQ = 3'd5;
  localparam logic [IDX_W-1:0] REG_OK_FREQ   = 3'd6;
  localparam logic [IDX_W-1:0] REG_CONFIRM   = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COUNT_W-1:0] beep_count;
    logic [FREQ_W-1:0]  beep_frequency;
  } in_req_t;

  typedef struct packed {
    logic              tone_active;
    logic [FREQ_W-1:0] tone_frequency;
    logic              alarm_active;
    logic              mute_status;
  } out_rsp_t;

  typedef struct packed {
    logic               buzzer_enable;
    logic [TICKS_W-1:0] alarm_on_ticks;
    logic [TICKS_W-1:0] alarm_off_ticks;
    logic [TICKS_W-1:0] beep_on_ticks;
    logic [TICKS_W-1:0] beep_off_ticks;
    logic [FREQ_W-1:0]  critical_frequency;
    logic [FREQ_W-1:0]  ok_frequency;
    logic [TICKS_W-1:0] confirm_ticks;
  } cfg_regs_t;

endpackage

`default_nettype wire

// File: hdl/bps_cfg.sv
// Configuration register file for the buzzer pattern sequencer.
`default_nettype none

module bps_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [bps_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [15:0]               cfg_data,
  output bps_pkg::cfg_regs_t             regs,
  output logic                           cfg_stop
);
  import bps_pkg::*;

  // Clearing the enable bit acts as a stop.
  assign cfg_stop = cfg_we && (cfg_index == REG_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.buzzer_enable      <= 1'b1;
      regs.alarm_on_ticks     <= 16'd200;
      regs.alarm_off_ticks    <= 16'd200;
      regs.beep_on_ticks      <= 16'd100;
      regs.beep_off_ticks     <= 16'd100;
      regs.critical_frequency <= 16'd2000;
      regs.ok_frequency       <= 16'd880;
      regs.confirm_ticks      <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    regs.buzzer_enable      <= cfg_data[0];
        REG_ALARM_ON:  regs.alarm_on_ticks     <= cfg_data;
        REG_ALARM_OFF: regs.alarm_off_ticks    <= cfg_data;
        REG_BEEP_ON:   regs.beep_on_ticks      <= cfg_data;
        REG_BEEP_OFF:  regs.beep_off_ticks     <= cfg_data;
        REG_CRIT_FREQ: regs.critical_frequency <= cfg_data;
        REG_OK_FREQ:   regs.ok_frequency       <= cfg_data;
        REG_CONFIRM:   regs.confirm_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/bps_seq.sv
// Sequencer state and single-pass next-state logic for ticks and commands.
`default_nettype none

module bps_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bps_pkg::cfg_regs_t  regs,
  input  wire logic                cfg_stop,
  input  wire logic                push,
  input  wire bps_pkg::in_req_t    req,
  output bps_pkg::out_rsp_t        rsp_next
);
  import bps_pkg::*;

  logic               muted_flag, muted_flag_next;
  logic               alarming_flag, alarming_flag_next;
  logic               phase_on, phase_on_next;
  logic [COUNT_W-1:0] beeps_left, beeps_left_next;
  logic [FREQ_W-1:0]  stored_freq, stored_freq_next;
  logic [EL_W-1:0]    phase_elapsed, phase_elapsed_next;
  logic [TICKS_W-1:0] confirm_left, confirm_left_next;
  logic               pin_on, pin_on_next;
  logic [FREQ_W-1:0]  pin_freq, pin_freq_next;

  logic               allowed;
  logic               changed;
  logic [EL_W-1:0]    el_inc;
  logic [COUNT_W-1:0] beeps_dec;

  assign allowed   = regs.buzzer_enable && !muted_flag;
  assign el_inc    = (&phase_elapsed) ? phase_elapsed : phase_elapsed + 1'b1;
  assign beeps_dec = beeps_left - 1'b1;

  always_comb begin
    muted_flag_next    = muted_flag;
    alarming_flag_next = alarming_flag;
    phase_on_next      = phase_on;
    beeps_left_next    = beeps_left;
    stored_freq_next   = stored_freq;
    phase_elapsed_next = phase_elapsed;
    confirm_left_next  = confirm_left;
    pin_on_next        = pin_on;
    pin_freq_next      = pin_freq;
    changed            = 1'b0;

    if (cfg_stop) begin
      alarming_flag_next = 1'b0;
      beeps_left_next    = '0;
      phase_on_next      = 1'b0;
      pin_on_next        = 1'b0;
      pin_freq_next      = '0;
      confirm_left_next  = '0;
    end else if (push) begin
      case (req.opcode)
        OP_TICK: begin
          phase_elapsed_next = el_inc;
          if (alarming_flag) begin
            if (phase_on && (el_inc >= {1'b0, regs.alarm_on_ticks})) begin
              pin_on_next        = 1'b0;
              pin_freq_next      = '0;
              phase_on_next      = 1'b0;
              phase_elapsed_next = '0;
              changed            = 1'b1;
            end else if (!phase_on && (el_inc >= {1'b0, regs.alarm_off_ticks})) begin
              pin_on_next        = 1'b1;
              pin_freq_next      = regs.critical_frequency;
              phase_on_next      = 1'b1;
              phase_elapsed_next = '0;
              changed            = 1'b1;
            end
          end else if (beeps_left != '0) begin
            if (phase_on && (el_inc >= {1'b0, regs.beep_on_ticks})) begin
              pin_on_next        = 1'b0;
              pin_freq_next      = '0;
              phase_on_next      = 1'b0;
              phase_elapsed_next = '0;
              changed            = 1'b1;
            end else if (!phase_on && (el_inc >= {1'b0, regs.beep_off_ticks})) begin
              beeps_left_next = beeps_dec;
              // start the next tone unless the run is done
              if (beeps_dec != '0) begin
                pin_on_next        = 1'b1;
                pin_freq_next      = stored_freq;
                phase_on_next      = 1'b1;
                phase_elapsed_next = '0;
                changed            = 1'b1;
              end
            end
          end
          // a pin change cancels the confirm tone; otherwise count it down
          if (changed) begin
            confirm_left_next = '0;
          end else if (confirm_left != '0) begin
            confirm_left_next = confirm_left - 1'b1;
            if (confirm_left == 16'd1) begin
              pin_on_next   = 1'b0;
              pin_freq_next = '0;
            end
          end
        end
        OP_ALARM: begin
          if (allowed) begin
            alarming_flag_next = 1'b1;
            phase_on_next      = 1'b1;
            phase_elapsed_next = '0;
            pin_on_next        = 1'b1;
            pin_freq_next      = regs.critical_frequency;
            confirm_left_next  = '0;
          end
        end
        OP_BEEP: begin
          if (allowed && !alarming_flag) begin
            beeps_left_next    = req.beep_count;
            stored_freq_next   = req.beep_frequency;
            phase_on_next      = 1'b1;
            phase_elapsed_next = '0;
            pin_on_next        = 1'b1;
            pin_freq_next      = req.beep_frequency;
            confirm_left_next  = '0;
          end
        end
        OP_CONFIRM: begin
          if (allowed) begin
            pin_on_next       = 1'b1;
            pin_freq_next     = regs.ok_frequency;
            confirm_left_next = regs.confirm_ticks;
          end
        end
        OP_STOP, OP_MUTE: begin
          if (req.opcode == OP_MUTE) begin
            muted_flag_next = 1'b1;
          end
          alarming_flag_next = 1'b0;
          beeps_left_next    = '0;
          phase_on_next      = 1'b0;
          pin_on_next        = 1'b0;
          pin_freq_next      = '0;
          confirm_left_next  = '0;
        end
        OP_UNMUTE: begin
          muted_flag_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp_next.tone_active    = pin_on_next;
    rsp_next.tone_frequency = pin_on_next ? pin_freq_next : '0;
    rsp_next.alarm_active   = alarming_flag_next;
    rsp_next.mute_status    = muted_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      muted_flag    <= 1'b0;
      alarming_flag <= 1'b0;
      phase_on      <= 1'b0;
      beeps_left    <= '0;
      stored_freq   <= '0;
      phase_elapsed <= '0;
      confirm_left  <= '0;
      pin_on        <= 1'b0;
      pin_freq      <= '0;
    end else begin
      muted_flag    <= muted_flag_next;
      alarming_flag <= alarming_flag_next;
      phase_on      <= phase_on_next;
      beeps_left    <= beeps_left_next;
      stored_freq   <= stored_freq_next;
      phase_elapsed <= phase_elapsed_next;
      confirm_left  <= confirm_left_next;
      pin_on        <= pin_on_next;
      pin_freq      <= pin_freq_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bps_out_buf.sv
// Two-entry result buffer between the sequencer and the output channel.
`default_nettype none

module bps_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire bps_pkg::out_rsp_t  push_data,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bps_pkg::out_rsp_t       out_rsp
);
  import bps_pkg::*;

  out_rsp_t    entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_rsp   = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/buzzer_pattern_sequencer_top.sv
// Top level of the buzzer pattern sequencer.
//
//   channel   direction  handshake             payload
//   in        request    in_valid / in_ready   in_req  (opcode, beep_count, beep_frequency)
//   out       result     out_valid / out_ready out_rsp (tone, frequency, alarm, mute)
//   cfg       write      cfg_we                cfg_index, cfg_data
//
// One request per cycle while in_ready is high; its result enters the result buffer on the cycle after acceptance.
// Every request, tick or command, yields exactly one result.
// A two-entry result buffer keeps in_ready high while one result waits;
// in_ready drops only when both entries are held.
// Synchronous reset restores the register defaults and clears all state.
`default_nettype none

module buzzer_pattern_sequencer_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire bps_pkg::in_req_t          in_req,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output bps_pkg::out_rsp_t              out_rsp,
  input  wire logic                      cfg_we,
  input  wire logic [bps_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [15:0]               cfg_data
);
  import bps_pkg::*;

  cfg_regs_t regs;
  logic      cfg_stop;
  logic      push;
  logic      full;
  out_rsp_t  rsp_next;

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  bps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .cfg_stop  (cfg_stop)
  );

  bps_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .cfg_stop (cfg_stop),
    .push     (push),
    .req      (in_req),
    .rsp_next (rsp_next)
  );

  bps_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rsp_next),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

// File: hdl/bps_checker.sv
// Port-level checker for the buzzer pattern sequencer, bound to the top level.
`default_nettype none

`include "buzzer_pattern_sequencer_top_macros.svh"

module bps_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire bps_pkg::out_rsp_t out_rsp
);
  import bps_pkg::*;

  logic rsp_stall;
  logic req_take;
  logic rsp_silent;
  logic rsp_muted;
  logic rsp_loud;

  assign rsp_stall  = out_valid && !out_ready;
  assign req_take   = in_valid && in_ready;
  assign rsp_silent = out_valid && !out_rsp.tone_active;
  assign rsp_muted  = out_valid && out_rsp.mute_status;
  assign rsp_loud   = out_rsp.tone_active || out_rsp.alarm_active;

  // hold a stalled result
  `BPS_ASSERT_NEXT(a_out_hold, rsp_stall, out_valid && $stable(out_rsp), "stalled result changed")

  // silence reads as frequency zero
  `BPS_ASSERT_NOW(a_silent_freq, rsp_silent, ~|out_rsp.tone_frequency, "silent with frequency")

  // muting drops every mode and tone
  `BPS_ASSERT_NOW(a_mute_quiet, rsp_muted, !rsp_loud, "muted result still sounding")

  // an accepted request always leaves a result behind
  `BPS_ASSERT_NEXT(a_result_follows, req_take, out_valid, "accepted request produced no result")

endmodule

bind buzzer_pattern_sequencer_top bps_checker u_bps_checker (.*);

`default_nettype wire

// File: test/tb_buzzer_pattern_sequencer_top.sv
// Self-checking testbench for the buzzer pattern sequencer top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_buzzer_pattern_sequencer_top;
  import bps_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_req_t in_req;
  logic out_valid;
  logic out_ready;
  out_rsp_t out_rsp;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  buzzer_pattern_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp(out_rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Predicted buzzer state and settings.
  cfg_regs_t   model_cfg;
  logic        muted;
  logic        alarming;
  logic        phase_on;
  logic [7:0]  beeps_left;
  logic [15:0] beep_freq;
  logic [31:0] elapsed;
  logic [15:0] confirm_left;
  logic        pin_on;
  logic [15:0] pin_freq;

  out_rsp_t expected_tones[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int rx_hold_len = 0;
  bit steady = 1'b0;

  function automatic cfg_regs_t make_settings(input logic en, input logic [15:0] aon,
                                              input logic [15:0] aoff, input logic [15:0] bon,
                                              input logic [15:0] boff, input logic [15:0] crit,
                                              input logic [15:0] okf, input logic [15:0] conf);
    cfg_regs_t s;
    s.buzzer_enable      = en;
    s.alarm_on_ticks     = aon;
    s.alarm_off_ticks    = aoff;
    s.beep_on_ticks      = bon;
    s.beep_off_ticks     = boff;
    s.critical_frequency = crit;
    s.ok_frequency       = okf;
    s.confirm_ticks      = conf;
    return s;
  endfunction

  function automatic void drive_pin(input logic on, input logic [15:0] f);
    pin_on = on;
    pin_freq = on ? f : 16'd0;
    confirm_left = 16'd0;
  endfunction

  function automatic void silence_all();
    alarming = 1'b0;
    beeps_left = 8'd0;
    phase_on = 1'b0;
    drive_pin(1'b0, 16'd0);
  endfunction

  function automatic void reset_model();
    model_cfg = make_settings(1'b1, 16'd200, 16'd200, 16'd100, 16'd100, 16'd2000, 16'd880,
                              16'd200);
    muted = 1'b0;
    alarming = 1'b0;
    phase_on = 1'b0;
    beeps_left = 8'd0;
    beep_freq = 16'd0;
    elapsed = 32'd0;
    confirm_left = 16'd0;
    pin_on = 1'b0;
    pin_freq = 16'd0;
  endfunction

  function automatic void apply_setting(input logic [IDX_W-1:0] idx, input logic [15:0] v);
    case (idx)
      REG_ENABLE: begin
        model_cfg.buzzer_enable = v[0];
        if (!v[0]) silence_all();
      end
      REG_ALARM_ON:  model_cfg.alarm_on_ticks = v;
      REG_ALARM_OFF: model_cfg.alarm_off_ticks = v;
      REG_BEEP_ON:   model_cfg.beep_on_ticks = v;
      REG_BEEP_OFF:  model_cfg.beep_off_ticks = v;
      REG_CRIT_FREQ: model_cfg.critical_frequency = v;
      REG_OK_FREQ:   model_cfg.ok_frequency = v;
      REG_CONFIRM:   model_cfg.confirm_ticks = v;
      default: ;
    endcase
  endfunction

  function automatic void tick_buzzer();
    logic changed;
    changed = 1'b0;
    if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 32'd1;
    if (alarming) begin
      if (phase_on && elapsed >= model_cfg.alarm_on_ticks) begin
        drive_pin(1'b0, 16'd0);
        phase_on = 1'b0;
        elapsed = 32'd0;
        changed = 1'b1;
      end else if (!phase_on && elapsed >= model_cfg.alarm_off_ticks) begin
        drive_pin(1'b1, model_cfg.critical_frequency);
        phase_on = 1'b1;
        elapsed = 32'd0;
        changed = 1'b1;
      end
    end else if (beeps_left != 8'd0) begin
      if (phase_on && elapsed >= model_cfg.beep_on_ticks) begin
        drive_pin(1'b0, 16'd0);
        phase_on = 1'b0;
        elapsed = 32'd0;
        changed = 1'b1;
      end else if (!phase_on && elapsed >= model_cfg.beep_off_ticks) begin
        beeps_left = beeps_left - 8'd1;
        if (beeps_left != 8'd0) begin
          drive_pin(1'b1, beep_freq);
          phase_on = 1'b1;
          elapsed = 32'd0;
          changed = 1'b1;
        end
      end
    end
    // A sequencer pin change cancels the confirm tone; otherwise count it down.
    if (!changed && confirm_left != 16'd0) begin
      confirm_left = confirm_left - 16'd1;
      if (confirm_left == 16'd0) begin
        pin_on = 1'b0;
        pin_freq = 16'd0;
      end
    end
  endfunction

  function automatic out_rsp_t predict_tone(input in_req_t req);
    out_rsp_t rsp;
    logic allowed;
    allowed = model_cfg.buzzer_enable && !muted;
    case (req.opcode)
      OP_TICK: tick_buzzer();
      OP_ALARM: begin
        if (allowed) begin
          alarming = 1'b1;
          phase_on = 1'b1;
          elapsed = 32'd0;
          drive_pin(1'b1, model_cfg.critical_frequency);
        end
      end
      OP_BEEP: begin
        if (allowed && !alarming) begin
          beeps_left = req.beep_count;
          beep_freq = req.beep_frequency;
          phase_on = 1'b1;
          elapsed = 32'd0;
          drive_pin(1'b1, req.beep_frequency);
        end
      end
      OP_CONFIRM: begin
        if (allowed) begin
          drive_pin(1'b1, model_cfg.ok_frequency);
          confirm_left = model_cfg.confirm_ticks;
        end
      end
      OP_STOP: silence_all();
      OP_MUTE: begin
        muted = 1'b1;
        silence_all();
      end
      OP_UNMUTE: muted = 1'b0;
      default: ;
    endcase
    rsp.tone_active = pin_on;
    rsp.tone_frequency = pin_on ? pin_freq : 16'd0;
    rsp.alarm_active = alarming;
    rsp.mute_status = muted;
    return rsp;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_req_t make_req(input logic [OP_W-1:0] op, input logic [7:0] cnt,
                                       input logic [15:0] f);
    in_req_t r;
    r.opcode = op;
    r.beep_count = cnt;
    r.beep_frequency = f;
    return r;
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int pick;
    r.beep_count = 8'($urandom_range(0, 255));
    r.beep_frequency = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 58) r.opcode = OP_TICK;
    else if (pick < 64) r.opcode = OP_ALARM;
    else if (pick < 76) begin
      r.opcode = OP_BEEP;
      if ($urandom_range(0, 9) < 7) r.beep_count = 8'($urandom_range(0, 4));
    end
    else if (pick < 83) r.opcode = OP_CONFIRM;
    else if (pick < 89) r.opcode = OP_STOP;
    else if (pick < 91) r.opcode = OP_MUTE;
    else if (pick < 97) r.opcode = OP_UNMUTE;
    else r.opcode = OP_SPARE;
    return r;
  endfunction

  task automatic send_request(input in_req_t req);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    expected_tones.push_back(predict_tone(req));
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    apply_setting(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_regs_t s);
    write_reg(REG_ENABLE, {15'd0, s.buzzer_enable});
    write_reg(REG_ALARM_ON, s.alarm_on_ticks);
    write_reg(REG_ALARM_OFF, s.alarm_off_ticks);
    write_reg(REG_BEEP_ON, s.beep_on_ticks);
    write_reg(REG_BEEP_OFF, s.beep_off_ticks);
    write_reg(REG_CRIT_FREQ, s.critical_frequency);
    write_reg(REG_OK_FREQ, s.ok_frequency);
    write_reg(REG_CONFIRM, s.confirm_ticks);
  endtask

  // Commands that start a tone are followed by a run of ticks to walk its phases.
  task automatic run_random(input int n);
    in_req_t r;
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      r = random_request();
      send_request(r);
      sent++;
      if (r.opcode == OP_ALARM || r.opcode == OP_BEEP || r.opcode == OP_CONFIRM) begin
        k = $urandom_range(1, 10);
        repeat (k) send_request(make_req(OP_TICK, 8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 65535))));
        sent += k;
      end
    end
  endtask

  task automatic test_directed();
    // Defaults after reset.
    send_request(make_req(OP_SPARE, 8'hFF, 16'hFFFF));
    send_request(make_req(OP_CONFIRM, 8'h00, 16'h0000));
    send_request(make_req(OP_TICK, 8'h00, 16'h0000));
    send_request(make_req(OP_BEEP, 8'd0, 16'd0));
    send_request(make_req(OP_TICK, 8'hFF, 16'hFFFF));
    send_request(make_req(OP_STOP, 8'h00, 16'h0000));
    send_request(make_req(OP_ALARM, 8'h00, 16'h0000));
    send_request(make_req(OP_BEEP, 8'd255, 16'hFFFF));
    send_request(make_req(OP_ALARM, 8'h00, 16'h0000));
    send_request(make_req(OP_MUTE, 8'h00, 16'h0000));
    send_request(make_req(OP_BEEP, 8'd3, 16'd440));
    send_request(make_req(OP_ALARM, 8'h00, 16'h0000));
    send_request(make_req(OP_CONFIRM, 8'h00, 16'h0000));
    send_request(make_req(OP_UNMUTE, 8'h00, 16'h0000));
    send_request(make_req(OP_BEEP, 8'd255, 16'hFFFF));
    send_request(make_req(OP_STOP, 8'h00, 16'h0000));
    quiesce();
    // Zero beep timing, short alarm timing and zero confirm duration.
    load_settings(make_settings(1'b1, 16'd1, 16'd2, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'd0));
    send_request(make_req(OP_CONFIRM, 8'h00, 16'h0000));
    send_request(make_req(OP_TICK, 8'h00, 16'h0000));
    send_request(make_req(OP_BEEP, 8'd2, 16'hA5A5));
    repeat (4) send_request(make_req(OP_TICK, 8'h00, 16'h0000));
    send_request(make_req(OP_ALARM, 8'h00, 16'h0000));
    send_request(make_req(OP_TICK, 8'h00, 16'h0000));
    quiesce();
    // Clearing the enable acts as stop, and later tone commands are ignored.
    write_reg(REG_ENABLE, 16'hFFFE);
    send_request(make_req(OP_ALARM, 8'h00, 16'h0000));
    send_request(make_req(OP_CONFIRM, 8'h00, 16'h0000));
    quiesce();
    write_reg(REG_ENABLE, 16'd1);
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    rx_hold_len = 200;
    repeat (40) send_request(random_request());
    steady = 1'b0;
    quiesce();
  endtask

  task automatic test_random_settings();
    load_settings(make_settings(1'b1, 16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                                16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 6))));
    steady = 1'b1;
    run_random(50);
    steady = 1'b0;
    run_random(100);
    quiesce();
    load_settings(make_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF));
    run_random(40);
    quiesce();
    load_settings(make_settings(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1));
    run_random(120);
    quiesce();
    load_settings(make_settings(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 8))));
    run_random(70);
    quiesce();
    write_reg(REG_ENABLE, 16'd0);
    run_random(20);
    quiesce();
    write_reg(REG_ENABLE, 16'd1);
    run_random(60);
    quiesce();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tones.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: tone %0b freq %0d alarm %0b mute %0b",
                   out_rsp.tone_active, out_rsp.tone_frequency, out_rsp.alarm_active,
                   out_rsp.mute_status);
      end else begin
        want = expected_tones.pop_front();
        if (out_rsp.tone_active !== want.tone_active ||
            out_rsp.tone_frequency !== want.tone_frequency ||
            out_rsp.alarm_active !== want.alarm_active ||
            out_rsp.mute_status !== want.mute_status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected tone %0b freq %0d alarm %0b mute %0b",
                     want.tone_active, want.tone_frequency, want.alarm_active,
                     want.mute_status);
            $display("          got      tone %0b freq %0d alarm %0b mute %0b",
                     out_rsp.tone_active, out_rsp.tone_frequency,
                     out_rsp.alarm_active, out_rsp.mute_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_settings();
    quiesce();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_tones.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/bps_pkg.sv
hdl/bps_cfg.sv
hdl/bps_seq.sv
hdl/bps_out_buf.sv
hdl/buzzer_pattern_sequencer_top.sv
hdl/bps_checker.sv
test/tb_buzzer_pattern_sequencer_top.sv
